>>> rtl/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// No dependencies; compiled first.
package hcbd_pkg;

  localparam int MAX_SIZE_DIGITS = 8;   // 1..15
  localparam int COUNT_BITS      = 32;  // 8..64
  localparam int LEN_BITS        = 32;
  localparam int CAP_BITS        = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_FORMAT   = 2'd2,
    KIND_CAPACITY = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic CFG_HEADERS_PRESENT = 1'b0;
  localparam logic CFG_MAX_BODY_LENGTH = 1'b1;

  typedef struct packed {
    logic                headers_present;
    logic [LEN_BITS-1:0] max_body_length;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [7:0]          out_byte;
    kind_t               kind;
    logic [LEN_BITS-1:0] body_length;
  } res_t;

endpackage

>>> rtl/hcbd_in_if.sv
// Input byte channel of the chunked body decoder.
// Depends on nothing but the handshake convention valid/ready.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_message;

  modport source (output valid, in_byte, start_message, input ready);
  modport sink   (input valid, in_byte, start_message, output ready);
endinterface

>>> rtl/hcbd_out_if.sv
// Result channel of the chunked body decoder.
// Depends on hcbd_pkg for the kind codes and length width.
interface hcbd_out_if import hcbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  kind_t               kind;
  logic [LEN_BITS-1:0] body_length;

  modport source (output valid, out_byte, kind, body_length, input ready);
  modport sink   (input valid, out_byte, kind, body_length, output ready);
endinterface

>>> rtl/hcbd_parser.sv
// Byte-wise chunked-encoding parser: state registers and next-state logic.
// Result is combinational from the accepted byte; depends on hcbd_pkg.
module hcbd_parser import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       start_message,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_LINE    = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  phase_t                phase_r, phase_nxt, ph;
  logic [1:0]            tm_r, tm_nxt, tm;
  logic [COUNT_BITS-1:0] cr_r, cr_nxt, cr, cr_dec;
  logic [3:0]            dc_r, dc_nxt, dc;
  logic [COUNT_BITS-1:0] pc_r, pc_nxt, pc;
  logic [4:0]            hex;
  logic [CAP_BITS-1:0]   total;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9")      r = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    return r;
  endfunction

  always_comb begin
    // start_message restarts the parser before this byte is parsed
    ph = start_message ? (cfg.headers_present ? PH_HEADER : PH_DIGITS) : phase_r;
    tm = start_message ? 2'd0 : tm_r;
    cr = start_message ? '0 : cr_r;
    dc = start_message ? 4'd0 : dc_r;
    pc = start_message ? '0 : pc_r;

    phase_nxt = ph;
    tm_nxt    = tm;
    cr_nxt    = cr;
    dc_nxt    = dc;
    pc_nxt    = pc;

    hex    = hex_decode(in_byte);
    cr_dec = cr - COUNT_BITS'(1);
    total  = CAP_BITS'(pc) + CAP_BITS'(cr);

    res.valid    = 1'b0;
    res.out_byte = 8'd0;
    res.kind     = KIND_BYTE;

    unique case (ph)
      PH_HEADER: begin
        if (in_byte == (tm[0] ? CHAR_LF : CHAR_CR)) begin
          if (tm == 2'd3) begin
            tm_nxt    = 2'd0;
            phase_nxt = PH_DIGITS;
          end else begin
            tm_nxt = tm + 2'd1;
          end
        end else begin
          tm_nxt = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_DIGITS: begin
        if (hex[4]) begin
          if (dc >= 4'(MAX_SIZE_DIGITS)) begin
            phase_nxt = PH_ERROR;
            res.valid = 1'b1;
            res.kind  = KIND_FORMAT;
          end else begin
            cr_nxt = {cr[COUNT_BITS-5:0], hex[3:0]};
            dc_nxt = dc + 4'd1;
          end
        end else if (dc == 4'd0) begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_FORMAT;
        end else begin
          phase_nxt = PH_LINE;
          tm_nxt    = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_LINE: begin
        if (tm == 2'd0) begin
          if (in_byte == CHAR_CR) tm_nxt = 2'd1;
        end else if (in_byte != CHAR_LF) begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_FORMAT;
        end else begin
          tm_nxt = 2'd0;
          if (cr == '0) begin
            phase_nxt = PH_DONE;
            res.valid = 1'b1;
            res.kind  = KIND_DONE;
          end else if (total > CAP_BITS'(cfg.max_body_length)) begin
            phase_nxt = PH_ERROR;
            res.valid = 1'b1;
            res.kind  = KIND_CAPACITY;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        pc_nxt       = pc + COUNT_BITS'(1);
        cr_nxt       = cr_dec;
        if (cr_dec == '0) phase_nxt = PH_DATA_CR;
        res.valid    = 1'b1;
        res.out_byte = in_byte;
      end
      PH_DATA_CR: begin
        if (in_byte != CHAR_CR) begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_FORMAT;
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (in_byte != CHAR_LF) begin
          phase_nxt = PH_ERROR;
          res.valid = 1'b1;
          res.kind  = KIND_FORMAT;
        end else begin
          phase_nxt = PH_DIGITS;
          dc_nxt    = 4'd0;
          cr_nxt    = '0;
        end
      end
      PH_DONE, PH_ERROR: begin
        // ignore everything until the next start
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    res.body_length = LEN_BITS'(CAP_BITS'(pc_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      tm_r    <= 2'd0;
      cr_r    <= '0;
      dc_r    <= 4'd0;
      pc_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tm_r    <= tm_nxt;
      cr_r    <= cr_nxt;
      dc_r    <= dc_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder, top level.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and hcbd_parser.
// Usage:
//  - in_chan carries the response stream, one byte per transfer, with
//    start_message set on the first byte of each response.
//  - out_chan carries at most one result per input byte: a payload byte
//    (kind 0), body complete (kind 1), format error (kind 2) or capacity
//    exceeded (kind 3), with the running payload byte count.
//  - cfg_we/cfg_index/cfg_data write headers_present (index 0) and
//    max_body_length (index 1); write them only while the block is idle.
//    headers_present applies at the next start_message.
// Timing: one byte per cycle sustained while in_chan.ready is high. Each
// result is registered in the output register, or in the skid register
// while out_chan stalls; the parser's state update is combinational, and
// its longest path is the 33-bit add-and-compare of the capacity check.
// Reset puts the parser in header skip with a zero count and restores
// the register defaults (headers_present 1, max_body_length all ones).
// When out_chan stalls, the output register holds its result and a skid
// register takes one more; in_chan.ready drops only while both are full,
// so no result is ever lost or repeated.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  hcbd_in_if.sink             in_chan,
  hcbd_out_if.source          out_chan,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LEN_BITS-1:0] cfg_data
);

  cfg_t cfg_r;
  res_t res;
  res_t out_r;
  res_t skid_r;
  logic accept;
  logic out_free;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.headers_present <= 1'b1;
      cfg_r.max_body_length <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADERS_PRESENT: cfg_r.headers_present <= cfg_data[0];
        CFG_MAX_BODY_LENGTH: cfg_r.max_body_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a new byte unless the skid slot is occupied
  assign in_chan.ready = !skid_r.valid;
  assign accept        = in_chan.valid && in_chan.ready;

  hcbd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .in_byte       (in_chan.in_byte),
    .start_message (in_chan.start_message),
    .res           (res)
  );

  // ---- output register + skid ----
  assign out_free = !out_r.valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else if (out_free) begin
      if (skid_r.valid) begin
        out_r        <= skid_r;
        skid_r.valid <= 1'b0;
      end else begin
        out_r.valid       <= accept && res.valid;
        out_r.out_byte    <= res.out_byte;
        out_r.kind        <= res.kind;
        out_r.body_length <= res.body_length;
      end
    end else if (accept && res.valid) begin
      // output stalled: park the new result
      skid_r <= res;
    end
  end

  assign out_chan.valid       = out_r.valid;
  assign out_chan.out_byte    = out_r.out_byte;
  assign out_chan.kind        = out_r.kind;
  assign out_chan.body_length = out_r.body_length;

  // ---- assertions ----
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("skid holds a result while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_r.valid) |-> $past(out_r.valid && !out_chan.ready))
    else $error("skid filled without an output stall");

  a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && out_r.kind != KIND_BYTE) |-> (out_r.out_byte == 8'd0))
    else $error("status result carries a nonzero byte");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_r.valid && !out_chan.ready) |=> skid_r.valid)
    else $error("skid lost a result while output stalled");

endmodule
